// File: sv/three_band_priority_fifo_top_macros.svh
// Assertion macros shared by the priority queue modules.
`ifndef THREE_BAND_PRIORITY_FIFO_TOP_MACROS_SVH
`define THREE_BAND_PRIORITY_FIFO_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define TBPF_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define TBPF_NEVER(name, clk, rst_n, expr, msg) \
  `TBPF_ASSERT(name, clk, rst_n, !(expr), msg)

`endif

// File: sv/tbpf_pkg.sv
// Types and constants of the three-band priority queue.
package tbpf_pkg;

  localparam int NumBands        = 3;
  localparam int BandW           = 2;
  localparam int PrioW           = 3;
  localparam int CmdW            = 2;
  localparam int FieldDescW      = 16;
  localparam int LimitW          = 7;
  localparam int MapW            = 16;
  localparam int CfgDataW        = 16;
  localparam int DropW           = 32;
  localparam int TotalW          = 9;

  localparam int BandDepthDefault = 128;
  localparam int DescBitsDefault  = 16;

  localparam logic [LimitW-1:0] LimitReset = 7'd100;
  localparam logic [MapW-1:0]   MapReset   = 16'd2473;

  localparam logic [BandW-1:0] BandTop = 2'd2;
  localparam logic [BandW-1:0] BandNone = 2'd3;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQ   = 2'd0,
    CMD_DEQ   = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic {
    REG_BAND_LIMIT = 1'b0,
    REG_BAND_MAP   = 1'b1
  } reg_idx_e;

  // Result fields settled at accept time; the descriptor joins at output.
  typedef struct packed {
    logic              accepted;
    logic              dropped;
    logic              deq_valid;
    logic [BandW-1:0]  band;
    logic [DropW-1:0]  drop_count;
    logic [TotalW-1:0] total_length;
  } res_meta_t;

endpackage

// File: sv/tbpf_store.sv
// Descriptor memory for all three bands: one write port, one registered read port.
module tbpf_store #(
  parameter int BAND_DEPTH = tbpf_pkg::BandDepthDefault,
  parameter int DESC_BITS  = tbpf_pkg::DescBitsDefault,
  parameter int ADDR_W     = $clog2(tbpf_pkg::NumBands * BAND_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic                 re_i,
  input  logic [ADDR_W-1:0]    addr_i,
  input  logic [DESC_BITS-1:0] wdata_i,
  output logic [DESC_BITS-1:0] rdata_o
);
  import tbpf_pkg::*;

  localparam int Depth = NumBands * BAND_DEPTH;

  logic [DESC_BITS-1:0] mem_q [Depth];
  logic [DESC_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  // Hold read data until the next read so a stalled result keeps its word.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/tbpf_ctrl.sv
// Band pointers, counts, drop counter, configuration and command decode.
`include "three_band_priority_fifo_top_macros.svh"

module tbpf_ctrl #(
  parameter int BAND_DEPTH = tbpf_pkg::BandDepthDefault,
  parameter int DESC_BITS  = tbpf_pkg::DescBitsDefault,
  parameter int ADDR_W     = $clog2(tbpf_pkg::NumBands * BAND_DEPTH)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  tbpf_pkg::cmd_e                  cmd_i,
  input  logic [tbpf_pkg::PrioW-1:0]      prio_i,
  input  logic [tbpf_pkg::FieldDescW-1:0] desc_i,
  input  logic                            cfg_we_i,
  input  tbpf_pkg::reg_idx_e              cfg_addr_i,
  input  logic [tbpf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output logic                            mem_we_o,
  output logic                            mem_re_o,
  output logic [ADDR_W-1:0]               mem_addr_o,
  output logic [DESC_BITS-1:0]            mem_wdata_o,
  output tbpf_pkg::res_meta_t             meta_o
);
  import tbpf_pkg::*;

  localparam int CntW = $clog2(BAND_DEPTH + 1);
  localparam int PtrW = $clog2(BAND_DEPTH);
  localparam int CmpW = (CntW > LimitW) ? CntW : LimitW;
  localparam int SumW = CntW + 2;

  logic [CntW-1:0]   count_q [NumBands];
  logic [CntW-1:0]   count_d [NumBands];
  logic [PtrW-1:0]   head_q  [NumBands];
  logic [PtrW-1:0]   head_d  [NumBands];
  logic [PtrW-1:0]   tail_q  [NumBands];
  logic [PtrW-1:0]   tail_d  [NumBands];
  logic [DropW-1:0]  drop_q, drop_d;
  logic [LimitW-1:0] limit_q;
  logic [MapW-1:0]   map_q;

  logic [BandW-1:0]  map_band, enq_band, deq_band, sel_band;
  logic              any_held, admit;
  logic [CntW-1:0]   cnt_sel;
  logic [PtrW-1:0]   ptr_sel, ptr_next;
  logic [SumW-1:0]   sum_after;

  // A map entry holding 3 folds onto the last band.
  assign map_band = map_q[{prio_i, 1'b0} +: BandW];
  assign enq_band = (map_band == BandNone) ? BandTop : map_band;

  always_comb begin
    any_held = 1'b1;
    deq_band = '0;
    priority if (count_q[0] != '0) begin
      deq_band = 2'd0;
    end else if (count_q[1] != '0) begin
      deq_band = 2'd1;
    end else if (count_q[2] != '0) begin
      deq_band = 2'd2;
    end else begin
      any_held = 1'b0;
    end
  end

  assign sel_band = (cmd_i == CMD_ENQ) ? enq_band : deq_band;
  assign cnt_sel  = count_q[sel_band];
  assign ptr_sel  = (cmd_i == CMD_ENQ) ? tail_q[sel_band] : head_q[sel_band];
  assign ptr_next = (ptr_sel == PtrW'(BAND_DEPTH - 1)) ? '0 : ptr_sel + PtrW'(1);
  assign admit    = (CmpW'(cnt_sel) <= CmpW'(limit_q)) && (cnt_sel < CntW'(BAND_DEPTH));

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    tail_d  = tail_q;
    drop_d  = drop_q;
    if (fire_i) begin
      unique case (cmd_i)
        CMD_ENQ: begin
          if (admit) begin
            tail_d[sel_band]  = ptr_next;
            count_d[sel_band] = cnt_sel + CntW'(1);
          end else begin
            drop_d = drop_q + DropW'(1);
          end
        end
        CMD_DEQ: begin
          if (any_held) begin
            head_d[sel_band]  = ptr_next;
            count_d[sel_band] = cnt_sel - CntW'(1);
          end
        end
        CMD_FLUSH: begin
          for (int b = 0; b < NumBands; b++) begin
            count_d[b] = '0;
            head_d[b]  = '0;
            tail_d[b]  = '0;
          end
        end
        CMD_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  assign sum_after = SumW'(count_d[0]) + SumW'(count_d[1]) + SumW'(count_d[2]);

  always_comb begin
    meta_o              = '0;
    meta_o.drop_count   = drop_d;
    meta_o.total_length = TotalW'(sum_after);
    unique case (cmd_i)
      CMD_ENQ: begin
        meta_o.band     = enq_band;
        meta_o.accepted = admit;
        meta_o.dropped  = !admit;
      end
      CMD_DEQ: begin
        meta_o.deq_valid = any_held;
        meta_o.band      = any_held ? deq_band : '0;
      end
      CMD_FLUSH, CMD_NOP: begin
      end
      default: begin
      end
    endcase
  end

  assign mem_we_o    = fire_i && (cmd_i == CMD_ENQ) && admit;
  assign mem_re_o    = fire_i && (cmd_i == CMD_DEQ) && any_held;
  assign mem_addr_o  = ADDR_W'(sel_band) * ADDR_W'(BAND_DEPTH) + ADDR_W'(ptr_sel);
  assign mem_wdata_o = DESC_BITS'(desc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NumBands; b++) begin
        count_q[b] <= '0;
        head_q[b]  <= '0;
        tail_q[b]  <= '0;
      end
      drop_q  <= '0;
      limit_q <= LimitReset;
      map_q   <= MapReset;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      drop_q  <= drop_d;
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_BAND_LIMIT: limit_q <= cfg_wdata_i[LimitW-1:0];
          REG_BAND_MAP:   map_q   <= cfg_wdata_i[MapW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  `TBPF_ASSERT(a_flush_clears, clk_i, rst_ni,
    fire_i && (cmd_i == CMD_FLUSH) |=>
      (count_q[0] == '0) && (count_q[1] == '0) && (count_q[2] == '0),
    "flush left a band non-empty")
  `TBPF_ASSERT(a_drop_only_on_drop, clk_i, rst_ni,
    !(fire_i && (cmd_i == CMD_ENQ) && !admit) |=> $stable(drop_q),
    "drop counter moved without a drop")
  `TBPF_NEVER(a_one_mem_access, clk_i, rst_ni, mem_we_o && mem_re_o,
    "memory read and write in one cycle")

endmodule

// File: sv/three_band_priority_fifo_top.sv
// Top level of the three-band strict-priority descriptor queue.
//
// Request channel (req_valid_i / req_ready_o) carries one command word:
// enqueue a descriptor at a priority, dequeue, flush all bands, or no-op.
// Result channel (res_valid_o / res_ready_i) returns exactly one word per
// command: accept/drop flags, dequeued descriptor and band, drop counter
// and the number of descriptors held after the command.
// Each command's descriptor memory read and pending stage load happen at
// the accept edge; the word moves on to the output register once the
// output is free. Throughput: one command per cycle while the output is
// not stalled; pointer and count updates complete in the accept cycle, so
// the next command sees them.
// A stalled receiver holds the output word; one further command is
// taken into the pending stage, then req_ready_o drops until the output
// frees up.
// Reset clears all bands, the drop counter and the pending stage, and
// loads band_limit = 100 and the default priority map. The descriptor
// memory needs no clearing pass: only written entries are ever read.
// Configuration writes (cfg_we_i) take effect at the write edge, without a wait.
`include "three_band_priority_fifo_top_macros.svh"

module three_band_priority_fifo_top #(
  parameter int BAND_DEPTH = tbpf_pkg::BandDepthDefault,
  parameter int DESC_BITS  = tbpf_pkg::DescBitsDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  output logic                            req_ready_o,
  input  logic [tbpf_pkg::CmdW-1:0]       command_i,
  input  logic [tbpf_pkg::PrioW-1:0]      priority_req_i,
  input  logic [tbpf_pkg::FieldDescW-1:0] descriptor_i,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output logic                            accepted_o,
  output logic                            dropped_now_o,
  output logic                            out_valid_o,
  output logic [tbpf_pkg::FieldDescW-1:0] out_descriptor_o,
  output logic [tbpf_pkg::BandW-1:0]      out_band_o,
  output logic [tbpf_pkg::DropW-1:0]      drop_count_o,
  output logic [tbpf_pkg::TotalW-1:0]     total_length_o,
  input  logic                            cfg_we_i,
  input  logic                            cfg_addr_i,
  input  logic [tbpf_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import tbpf_pkg::*;

  localparam int AddrW = $clog2(NumBands * BAND_DEPTH);

  logic                  fire, out_free, move;
  logic                  mem_we, mem_re;
  logic [AddrW-1:0]      mem_addr;
  logic [DESC_BITS-1:0]  mem_wdata, mem_rdata;
  res_meta_t             meta;
  logic                  pend_q, pend_d;
  res_meta_t             pend_meta_q;
  logic                  res_valid_q, res_valid_d;
  res_meta_t             res_meta_q;
  logic [FieldDescW-1:0] res_desc_q;

  assign out_free    = !res_valid_q || res_ready_i;
  assign move        = pend_q && out_free;
  assign req_ready_o = !pend_q || out_free;
  assign fire        = req_valid_i && req_ready_o;

  tbpf_ctrl #(
    .BAND_DEPTH(BAND_DEPTH),
    .DESC_BITS (DESC_BITS),
    .ADDR_W    (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .cmd_i      (cmd_e'(command_i)),
    .prio_i     (priority_req_i),
    .desc_i     (descriptor_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (reg_idx_e'(cfg_addr_i)),
    .cfg_wdata_i(cfg_wdata_i),
    .mem_we_o   (mem_we),
    .mem_re_o   (mem_re),
    .mem_addr_o (mem_addr),
    .mem_wdata_o(mem_wdata),
    .meta_o     (meta)
  );

  tbpf_store #(
    .BAND_DEPTH(BAND_DEPTH),
    .DESC_BITS (DESC_BITS),
    .ADDR_W    (AddrW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .re_i   (mem_re),
    .addr_i (mem_addr),
    .wdata_i(mem_wdata),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    pend_d = pend_q;
    if (fire) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (move) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload stages: pending meta on accept, output word on advance.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      pend_meta_q <= meta;
    end
    if (move) begin
      res_meta_q <= pend_meta_q;
      res_desc_q <= pend_meta_q.deq_valid ? FieldDescW'(mem_rdata) : '0;
    end
  end

  assign res_valid_o      = res_valid_q;
  assign accepted_o       = res_meta_q.accepted;
  assign dropped_now_o    = res_meta_q.dropped;
  assign out_valid_o      = res_meta_q.deq_valid;
  assign out_descriptor_o = res_desc_q;
  assign out_band_o       = res_meta_q.band;
  assign drop_count_o     = res_meta_q.drop_count;
  assign total_length_o   = res_meta_q.total_length;

  `TBPF_ASSERT(a_pend_holds_on_stall, clk_i, rst_ni,
    pend_q && res_valid_q && !res_ready_i |=> pend_q && $stable(pend_meta_q),
    "pending word lost while output stalled")

endmodule

// File: dv/three_band_priority_fifo_top_tb.sv
// Self-checking testbench for the three-band strict-priority descriptor queue.
`timescale 1ns / 1ps

module three_band_priority_fifo_top_tb;
  import tbpf_pkg::*;

  localparam int BandDepth  = BandDepthDefault;
  localparam int LongHold   = 150;
  localparam int QuietLimit = 1000;

  typedef struct packed {
    logic                  accepted;
    logic                  dropped;
    logic                  deq_valid;
    logic [FieldDescW-1:0] descriptor;
    logic [BandW-1:0]      band;
    logic [DropW-1:0]      drop_count;
    logic [TotalW-1:0]     total_length;
  } queue_outcome_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  req_valid_i    = 1'b0;
  logic                  req_ready_o;
  logic [CmdW-1:0]       command_i      = '0;
  logic [PrioW-1:0]      priority_req_i = '0;
  logic [FieldDescW-1:0] descriptor_i   = '0;
  logic                  res_valid_o;
  logic                  res_ready_i    = 1'b0;
  logic                  accepted_o;
  logic                  dropped_now_o;
  logic                  out_valid_o;
  logic [FieldDescW-1:0] out_descriptor_o;
  logic [BandW-1:0]      out_band_o;
  logic [DropW-1:0]      drop_count_o;
  logic [TotalW-1:0]     total_length_o;
  logic                  cfg_we_i       = 1'b0;
  logic                  cfg_addr_i     = 1'b0;
  logic [CfgDataW-1:0]   cfg_wdata_i    = '0;

  three_band_priority_fifo_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_valid_i      (req_valid_i),
    .req_ready_o      (req_ready_o),
    .command_i        (command_i),
    .priority_req_i   (priority_req_i),
    .descriptor_i     (descriptor_i),
    .res_valid_o      (res_valid_o),
    .res_ready_i      (res_ready_i),
    .accepted_o       (accepted_o),
    .dropped_now_o    (dropped_now_o),
    .out_valid_o      (out_valid_o),
    .out_descriptor_o (out_descriptor_o),
    .out_band_o       (out_band_o),
    .drop_count_o     (drop_count_o),
    .total_length_o   (total_length_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  // Mirror of the queue state
  logic [FieldDescW-1:0] band_mem [NumBands][BandDepth];
  int unsigned           band_head [NumBands];
  int unsigned           band_tail [NumBands];
  int unsigned           band_fill [NumBands];
  logic [DropW-1:0]      drop_total   = '0;
  logic [LimitW-1:0]     band_limit   = LimitReset;
  logic [MapW-1:0]       band_map     = MapReset;

  queue_outcome_t pending_outcomes[$];
  int             mismatch_count = 0;
  int             tx_max_gap     = 0;
  int             rx_max_gap     = 0;
  bit             rx_long_hold   = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic int draw_gap(int max_gap);
    return (max_gap == 0) ? 0 : int'($urandom_range(0, max_gap));
  endfunction

  // Advance the mirrored queue by one command and return the word it yields.
  function automatic queue_outcome_t apply_command(cmd_e cmd, logic [PrioW-1:0] prio,
                                                   logic [FieldDescW-1:0] desc);
    queue_outcome_t   o;
    logic [BandW-1:0] b;
    bit               found;
    o = '0;
    found = 1'b0;
    case (cmd)
      CMD_ENQ: begin
        b = band_map[prio*BandW +: BandW];
        if (b == BandNone) b = BandTop;
        o.band = b;
        if (band_fill[b] <= band_limit && band_fill[b] < BandDepth) begin
          band_mem[b][band_tail[b]] = desc;
          band_tail[b] = (band_tail[b] + 1) % BandDepth;
          band_fill[b]++;
          o.accepted = 1'b1;
        end else begin
          drop_total++;
          o.dropped = 1'b1;
        end
      end
      CMD_DEQ: begin
        for (int i = 0; i < NumBands; i++) begin
          if (!found && band_fill[i] != 0) begin
            found = 1'b1;
            o.descriptor = band_mem[i][band_head[i]];
            band_head[i] = (band_head[i] + 1) % BandDepth;
            band_fill[i]--;
            o.deq_valid = 1'b1;
            o.band = BandW'(i);
          end
        end
      end
      CMD_FLUSH: begin
        for (int i = 0; i < NumBands; i++) begin
          band_head[i] = 0;
          band_tail[i] = 0;
          band_fill[i] = 0;
        end
      end
      default: ;
    endcase
    o.drop_count = drop_total;
    o.total_length = TotalW'(band_fill[0] + band_fill[1] + band_fill[2]);
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Offer one command word; returns at the edge that accepted it.
  task automatic send_word(cmd_e cmd, logic [PrioW-1:0] prio, logic [FieldDescW-1:0] desc);
    int gap;
    gap = draw_gap(tx_max_gap);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i    <= 1'b1;
    command_i      <= cmd;
    priority_req_i <= prio;
    descriptor_i   <= desc;
    @(posedge clk_i);
    while (!req_ready_o) @(posedge clk_i);
    pending_outcomes.push_back(apply_command(cmd, prio, desc));
  endtask

  task automatic send_random_word(int enq_pct, int deq_pct, int flush_pct);
    int   r;
    cmd_e cmd;
    r = $urandom_range(0, 99);
    if (r < enq_pct) cmd = CMD_ENQ;
    else if (r < enq_pct + deq_pct) cmd = CMD_DEQ;
    else if (r < enq_pct + deq_pct + flush_pct) cmd = CMD_FLUSH;
    else cmd = CMD_NOP;
    send_word(cmd, PrioW'($urandom_range(0, 7)), FieldDescW'($urandom_range(0, 65535)));
  endtask

  // Drop valid and hold until every outstanding word has come back.
  task automatic wait_queue_idle();
    req_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only called while idle; the mirror takes the value at the write edge.
  task automatic write_reg(reg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == REG_BAND_LIMIT) band_limit = data[LimitW-1:0];
    else band_map = data[MapW-1:0];
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_default_map();
    tx_max_gap = 2;
    rx_max_gap = 2;
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_ENQ, 3'd0, 16'h0000);
    send_word(CMD_ENQ, 3'd1, 16'hFFFF);
    send_word(CMD_ENQ, 3'd2, 16'h5A5A);
    send_word(CMD_ENQ, 3'd3, 16'hA5A5);
    send_word(CMD_ENQ, 3'd4, 16'h1234);
    send_word(CMD_ENQ, 3'd5, 16'hFEDC);
    send_word(CMD_ENQ, 3'd6, 16'h8001);
    send_word(CMD_ENQ, 3'd7, 16'h7FFE);
    send_word(CMD_NOP, 3'd7, 16'hFFFF);
    repeat (4) send_word(CMD_DEQ, 3'd7, 16'hFFFF);
    // flush with four still held, then confirm empty
    send_word(CMD_FLUSH, 3'd5, 16'hA5A5);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_ENQ, 3'd7, 16'hFFFF);
    send_word(CMD_ENQ, 3'd1, 16'h0001);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_NOP, 3'd0, 16'h0000);
    wait_queue_idle();
  endtask

  task automatic test_map_extremes();
    tx_max_gap = 3;
    rx_max_gap = 0;
    // every entry 3: all priorities fold into the top band; limit 0 keeps one
    write_reg(REG_BAND_LIMIT, 16'd0);
    write_reg(REG_BAND_MAP, 16'hFFFF);
    send_word(CMD_ENQ, 3'd0, 16'hC3C3);
    send_word(CMD_ENQ, 3'd3, 16'h3C3C);
    send_word(CMD_ENQ, 3'd7, 16'hFFFF);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    wait_queue_idle();
    write_reg(REG_BAND_MAP, 16'h0000);
    send_word(CMD_ENQ, 3'd5, 16'h0F0F);
    send_word(CMD_ENQ, 3'd2, 16'hF0F0);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    send_word(CMD_DEQ, 3'd0, 16'h0000);
    wait_queue_idle();
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < 4; k++) begin
      tx_max_gap = (k % 2) ? 10 : 0;
      rx_max_gap = (k < 2) ? 10 : 0;
      write_reg(REG_BAND_LIMIT, (k == 0) ? 16'd0 : CfgDataW'($urandom_range(1, 15)));
      write_reg(REG_BAND_MAP, CfgDataW'($urandom_range(0, 65535)));
      repeat (30) send_random_word(55, 38, 3);
      // sender pause until the queue has answered everything
      wait_queue_idle();
      repeat (25) send_random_word(45, 45, 5);
      wait_queue_idle();
    end
  endtask

  task automatic test_full_occupancy();
    // band is priority modulo four (3 folds onto band 2); largest limit lets each band fill to depth
    write_reg(REG_BAND_LIMIT, 16'd127);
    write_reg(REG_BAND_MAP, 16'hE4E4);
    tx_max_gap = 3;
    rx_max_gap = 0;
    repeat (225) send_random_word(97, 2, 0);
    tx_max_gap = 0;
    rx_max_gap = 4;
    repeat (225) send_random_word(97, 2, 0);
    wait_queue_idle();
    tx_max_gap = 0;
    rx_max_gap = 10;
    repeat (210) send_random_word(2, 97, 0);
    tx_max_gap = 10;
    rx_max_gap = 0;
    repeat (210) send_random_word(2, 97, 0);
    wait_queue_idle();
  endtask

  task automatic test_output_stall();
    write_reg(REG_BAND_LIMIT, 16'd20);
    write_reg(REG_BAND_MAP, CfgDataW'($urandom_range(0, 65535)));
    tx_max_gap = 0;
    rx_max_gap = 0;
    rx_long_hold = 1'b1;
    repeat (40) send_random_word(60, 35, 2);
    wait_queue_idle();
  endtask

  initial begin : stimulus
    for (int i = 0; i < NumBands; i++) begin
      band_head[i] = 0;
      band_tail[i] = 0;
      band_fill[i] = 0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_map();
    test_map_extremes();
    test_random_mix();
    test_full_occupancy();
    test_output_stall();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : result_checker
    int             gap;
    queue_outcome_t want;
    forever begin
      if (rx_long_hold) begin
        gap = LongHold;
        rx_long_hold = 1'b0;
      end else begin
        gap = draw_gap(rx_max_gap);
      end
      if (gap > 0) begin
        res_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!(res_valid_o && rst_ni)) @(posedge clk_i);
      if (pending_outcomes.size() == 0) begin
        $error("result word with no command outstanding");
        mismatch_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("accepted", want.accepted, accepted_o);
        check_field("dropped_now", want.dropped, dropped_now_o);
        check_field("out_valid", want.deq_valid, out_valid_o);
        check_field("out_descriptor", want.descriptor, out_descriptor_o);
        check_field("out_band", want.band, out_band_o);
        check_field("drop_count", want.drop_count, drop_count_o);
        check_field("total_length", want.total_length, total_length_o);
      end
    end
  end

  // End the run if neither channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || (req_valid_i && req_ready_o) || (res_valid_o && res_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= QuietLimit) begin
        $error("no handshake for %0d cycles, %0d words outstanding",
               quiet, pending_outcomes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

// File: sim.f
+incdir+sv
sv/tbpf_pkg.sv
sv/tbpf_store.sv
sv/tbpf_ctrl.sv
sv/three_band_priority_fifo_top.sv
dv/three_band_priority_fifo_top_tb.sv
